/* sv/gas_pkg.sv */
// Package for the global alignment score block: payload structs, register
// indexes, reset values, sequencer states and cell unit operations.
// No dependencies.
package gas_pkg;

    localparam int SYM_W     = 8;
    localparam int SCORE_W   = 16;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd2;

    localparam logic [CFG_W-1:0] GAP_RESET      = 8'd1;
    localparam logic [CFG_W-1:0] MISMATCH_RESET = 8'd2;
    localparam logic [CFG_W-1:0] MATCH_RESET    = 8'd4;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7FFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             which_sequence;
        logic             symbol_present;
        logic             last;
    } item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      overflow;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] gap;
        logic [CFG_W-1:0] mismatch;
        logic [CFG_W-1:0] match;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROW_START,
        S_ROW,
        S_DONE
    } state_t;

    typedef enum logic {
        OP_STEP,
        OP_CELL
    } op_t;

endpackage

/* sv/global_alignment_score.sv */
// Global alignment score (linear gap): symbol load, row sequencer, score out.
// Loading: a request without last keeps the block idle; start may be high again next cycle.
// Scoring: a last request starts an init pass on row 0, then n rows of a column-zero step and
// m cell updates (n, m = lengths); the receiver cannot stall, busy drops the cycle after done.
// Reset: registers return to 1/2/4, lengths and overflow clear at once; no store clearing pass.
// Depends on gas_pkg, gas_ram, gas_cell_unit.
module global_alignment_score #(
    parameter int MAX_LEN = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  gas_pkg::item_t                  item,
    output logic                            done,
    output gas_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gas_pkg::CFG_W-1:0]       cfg_data
);
    import gas_pkg::*;

    // Sequence lengths run 0..MAX_LEN; the row has MAX_LEN+1 entries.
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int ROW_AW    = LEN_W;
    localparam int SYM_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // Any path score is bounded by (n+m)*255 in magnitude.
    localparam int ROW_W_MIN = $clog2(2 * MAX_LEN * 256) + 2;
    localparam int ROW_W     = (ROW_W_MIN > SCORE_W + 1) ? ROW_W_MIN : SCORE_W + 1;

    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_LEN);
    localparam logic signed [ROW_W-1:0] SAT_HI = ROW_W'(SCORE_MAX);
    localparam logic signed [ROW_W-1:0] SAT_LO = ROW_W'(SCORE_MIN);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    cfg_t                    cfg_reg;
    logic [LEN_W-1:0]        first_len_reg, first_len_next;
    logic [LEN_W-1:0]        second_len_reg, second_len_next;
    logic                    dropped_reg, dropped_next;
    logic [LEN_W-1:0]        i_reg, i_next;      // current row, 1-based
    logic [LEN_W-1:0]        j_reg, j_next;      // current column
    logic signed [ROW_W-1:0] col0_reg, col0_next; // -gap * i
    logic signed [ROW_W-1:0] left_reg, left_next;
    logic signed [ROW_W-1:0] diag_reg, diag_next;
    logic signed [ROW_W-1:0] last_reg, last_next; // last written row entry

    logic accept;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Configuration: hold writes off while a score pass runs.
    // ------------------------------------------------------------------
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap      <= GAP_RESET;
            cfg_reg.mismatch <= MISMATCH_RESET;
            cfg_reg.match    <= MATCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAP:      cfg_reg.gap      <= cfg_data;
                REG_MISMATCH: cfg_reg.mismatch <= cfg_data;
                REG_MATCH:    cfg_reg.match    <= cfg_data;
                default:      ;  // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Symbol stores: append at the current length while room remains.
    // ------------------------------------------------------------------
    logic first_we, second_we;
    logic first_full, second_full;
    logic [LEN_W-1:0] i_minus1;
    logic [SYM_AW-1:0] first_rd_addr, second_rd_addr;
    logic [SYM_W-1:0]  first_rd, second_rd;

    assign first_full  = (first_len_reg == LEN_FULL);
    assign second_full = (second_len_reg == LEN_FULL);
    assign first_we  = accept && item.symbol_present && !item.which_sequence && !first_full;
    assign second_we = accept && item.symbol_present && item.which_sequence && !second_full;

    assign i_minus1 = i_reg - LEN_W'(1);
    // Hold the first-sequence address on symbol i-1 through the whole row.
    assign first_rd_addr = i_minus1[SYM_AW-1:0];

    gas_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (SYM_W),
        .AW    (SYM_AW)
    ) u_first_mem (
        .clk     (clk),
        .we      (first_we),
        .wr_addr (first_len_reg[SYM_AW-1:0]),
        .wr_data (item.symbol),
        .rd_addr (first_rd_addr),
        .rd_data (first_rd)
    );

    gas_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (SYM_W),
        .AW    (SYM_AW)
    ) u_second_mem (
        .clk     (clk),
        .we      (second_we),
        .wr_addr (second_len_reg[SYM_AW-1:0]),
        .wr_data (item.symbol),
        .rd_addr (second_rd_addr),
        .rd_data (second_rd)
    );

    // ------------------------------------------------------------------
    // Score row and shared cell unit
    // ------------------------------------------------------------------
    logic                    row_we;
    logic [ROW_AW-1:0]       row_rd_addr;
    logic [ROW_AW-1:0]       j_plus1;
    logic signed [ROW_W-1:0] row_wr_data;
    logic signed [ROW_W-1:0] row_rd;
    logic signed [ROW_W-1:0] unit_left;
    logic signed [ROW_W-1:0] unit_out;
    op_t                     unit_op;
    logic                    use_col0;

    assign j_plus1 = j_reg + LEN_W'(1);

    gas_ram #(
        .DEPTH (MAX_LEN + 1),
        .WIDTH (ROW_W),
        .AW    (ROW_AW)
    ) u_row_mem (
        .clk     (clk),
        .we      (row_we),
        .wr_addr (j_reg),
        .wr_data (row_wr_data),
        .rd_addr (row_rd_addr),
        .rd_data (row_rd)
    );

    assign unit_left = use_col0 ? col0_reg : left_reg;

    gas_cell_unit #(
        .W (ROW_W)
    ) u_cell (
        .op    (unit_op),
        .cfg   (cfg_reg),
        .diag  (diag_reg),
        .up    (row_rd),
        .left  (unit_left),
        .sym_a (first_rd),
        .sym_b (second_rd),
        .out   (unit_out)
    );

    // Column zero of the row is always zero in the init pass.
    assign row_wr_data = (state_reg == S_INIT && j_reg == '0) ? '0 : unit_out;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && item.last)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (j_reg == second_len_reg)
                begin
                    state_next = (first_len_reg == '0) ? S_DONE : S_ROW_START;
                end
            end
            S_ROW_START:
            begin
                if (second_len_reg == '0)
                begin
                    state_next = (i_reg == first_len_reg) ? S_DONE : S_ROW_START;
                end
                else
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                if (j_reg == second_len_reg)
                begin
                    state_next = (i_reg == first_len_reg) ? S_DONE : S_ROW_START;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        busy           = 1'b1;
        done           = 1'b0;
        row_we         = 1'b0;
        unit_op        = OP_STEP;
        use_col0       = 1'b0;
        row_rd_addr    = j_plus1;
        second_rd_addr = j_reg[SYM_AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
            end
            S_INIT:
            begin
                row_we = 1'b1;
            end
            S_ROW_START:
            begin
                // Step column zero; fetch row[1] and the first second-sequence symbol.
                use_col0       = 1'b1;
                row_rd_addr    = ROW_AW'(1);
                second_rd_addr = '0;
            end
            S_ROW:
            begin
                // Write cell j, fetch cell j+1 and symbol j.
                row_we  = 1'b1;
                unit_op = OP_CELL;
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        dropped_next    = dropped_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        col0_next       = col0_reg;
        left_next       = left_reg;
        diag_next       = diag_reg;
        last_next       = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                j_next = '0;
                if (first_we)
                begin
                    first_len_next = first_len_reg + LEN_W'(1);
                end
                if (second_we)
                begin
                    second_len_next = second_len_reg + LEN_W'(1);
                end
                if (accept && item.symbol_present &&
                    ((!item.which_sequence && first_full) ||
                     (item.which_sequence && second_full)))
                begin
                    dropped_next = 1'b1;
                end
            end
            S_INIT:
            begin
                left_next = row_wr_data;
                last_next = row_wr_data;
                j_next    = j_plus1;
                if (j_reg == second_len_reg)
                begin
                    i_next    = LEN_W'(1);
                    col0_next = '0;
                end
            end
            S_ROW_START:
            begin
                col0_next = unit_out;
                left_next = unit_out;
                diag_next = col0_reg;
                last_next = unit_out;
                j_next    = LEN_W'(1);
                if (second_len_reg == '0)
                begin
                    i_next = i_reg + LEN_W'(1);
                end
            end
            S_ROW:
            begin
                left_next = unit_out;
                diag_next = row_rd;
                last_next = unit_out;
                j_next    = j_plus1;
                if (j_reg == second_len_reg)
                begin
                    i_next = i_reg + LEN_W'(1);
                end
            end
            S_DONE:
            begin
                // End of data set: clear lengths and the drop flag.
                first_len_next  = '0;
                second_len_next = '0;
                dropped_next    = 1'b0;
            end
            default:
            begin
                j_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            dropped_reg    <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            dropped_reg    <= dropped_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col0_reg <= col0_next;
        left_reg <= left_next;
        diag_reg <= diag_next;
        last_reg <= last_next;
    end

    // ------------------------------------------------------------------
    // Result: the last written row entry is row[m] of the final row.
    // Saturate it to the 16-bit score range.
    // ------------------------------------------------------------------
    always_comb
    begin
        result.overflow = dropped_reg;
        priority if (last_reg > SAT_HI)
        begin
            result.score = SCORE_MAX;
        end
        else if (last_reg < SAT_LO)
        begin
            result.score = SCORE_MIN;
        end
        else
        begin
            result.score = last_reg[SCORE_W-1:0];
        end
    end

endmodule

/* sv/gas_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
// Used for the symbol stores and the working score row. No dependencies.
module gas_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we && (int'(wr_addr) < DEPTH))
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (int'(rd_addr) < DEPTH)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/gas_cell_unit.sv */
// Shared arithmetic unit of the alignment sequencer: one gap step or one
// full cell update (best of diagonal, up and left). Depends on gas_pkg.
module gas_cell_unit #(
    parameter int W = 17
) (
    input  gas_pkg::op_t                op,
    input  gas_pkg::cfg_t               cfg,
    input  logic signed [W-1:0]         diag,
    input  logic signed [W-1:0]         up,
    input  logic signed [W-1:0]         left,
    input  logic [gas_pkg::SYM_W-1:0]   sym_a,
    input  logic [gas_pkg::SYM_W-1:0]   sym_b,
    output logic signed [W-1:0]         out
);
    import gas_pkg::*;

    logic signed [W-1:0] gap_ext;
    logic signed [W-1:0] pair;
    logic signed [W-1:0] from_diag;
    logic signed [W-1:0] from_up;
    logic signed [W-1:0] from_left;
    logic signed [W-1:0] best_du;

    assign gap_ext   = $signed({{(W-CFG_W){1'b0}}, cfg.gap});
    assign pair      = (sym_a == sym_b) ? $signed({{(W-CFG_W){1'b0}}, cfg.match})
                                        : -$signed({{(W-CFG_W){1'b0}}, cfg.mismatch});
    assign from_diag = diag + pair;
    assign from_up   = up - gap_ext;
    assign from_left = left - gap_ext;
    assign best_du   = (from_diag > from_up) ? from_diag : from_up;

    always_comb
    begin
        unique case (op)
            OP_STEP: out = from_left;
            OP_CELL: out = (best_du > from_left) ? best_du : from_left;
            default: out = from_left;
        endcase
    end

endmodule

/* sv/gas_checker.sv */
// Port-level checker for global_alignment_score and its bind statement.
// Depends on gas_pkg.
module gas_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input gas_pkg::item_t item
);

    // A result only appears while the block is working on a last request.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // The result strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // A request without last keeps the block ready.
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last) |=> !busy)
        else $error("busy after a load request");

    // A last request starts the score pass.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last) |=> busy)
        else $error("no score pass after a last request");

    // The block only goes idle right after delivering a result.
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

endmodule

bind global_alignment_score gas_checker u_gas_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .item  (item)
);

/* tb/tb_global_alignment_score.sv */
// Self-checking testbench for global_alignment_score: a directed table and
// then random data sets, scored against an in-bench linear-gap global alignment predictor.
// Depends on gas_pkg and the global_alignment_score RTL.
`timescale 1ns / 100ps

module tb_global_alignment_score;

    import gas_pkg::*;

    localparam int MAX_LEN        = 64;
    localparam int DIRECTED_ROWS  = 22;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_REQUESTS = 222;
    // Extra idle time after busy has dropped, kept as margin.
    localparam int SETTLE_CYCLES  = 4;
    // Watchdog limit, set with ample headroom over the slowest legal run.
    localparam int CYCLE_LIMIT    = 500000;

    // Register index the block does not decode; a write there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        item_t                     req;
        logic                      typed;
        logic signed [SCORE_W-1:0] score;
        logic                      overflow;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  done;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    global_alignment_score #(
        .MAX_LEN (MAX_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the sequences, lengths, drop flag
    // and the three scoring registers (reset values from the package).
    // ------------------------------------------------------------------
    logic [SYM_W-1:0] first_seq  [0:MAX_LEN-1];
    logic [SYM_W-1:0] second_seq [0:MAX_LEN-1];
    int               first_len     = 0;
    int               second_len    = 0;
    logic             symbols_lost  = 1'b0;
    logic [CFG_W-1:0] gap_cost      = GAP_RESET;
    logic [CFG_W-1:0] mismatch_cost = MISMATCH_RESET;
    logic [CFG_W-1:0] match_bonus   = MATCH_RESET;

    // Scores still owed by the block, oldest first.
    result_t          scores_due [$];

    directed_row_t    directed_rows [0:DIRECTED_ROWS-1];

    int               errors        = 0;
    int               cycle_count   = 0;
    int               request_count = 0;
    int               scored_sets   = 0;
    int               lost_sets     = 0;
    int               burst_left    = 0;
    bit               gaps_on       = 1'b1;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d scores outstanding",
                     cycle_count, scores_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, so every strobe seen at
    // a rising edge is a delivered score. Compare it with the oldest one due.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (scores_due.size() == 0)
            begin
                $error("unexpected score %0d (overflow %0b) with nothing due",
                       result.score, result.overflow);
                errors++;
            end
            else
            begin
                want = scores_due.pop_front();
                if (result.score !== want.score)
                begin
                    $error("score: expected %0d, got %0d", want.score, result.score);
                    errors++;
                end
                if (result.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, result.overflow);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Best global alignment score of the two stored sequences, one score row
    // kept in int so no intermediate value wraps, then clamped to 16 bits.
    function automatic logic signed [SCORE_W-1:0] alignment_score();
        int row [0:MAX_LEN];
        int diag;
        int up;
        int pair;
        int best;
        int gap;
        int i;
        int j;
        gap = int'(gap_cost);
        for (j = 0; j <= second_len; j++)
            row[j] = -gap * j;
        for (i = 1; i <= first_len; i++)
        begin
            diag   = row[0];
            row[0] = -gap * i;
            for (j = 1; j <= second_len; j++)
            begin
                up   = row[j];
                pair = (first_seq[i-1] == second_seq[j-1]) ? int'(match_bonus)
                                                           : -int'(mismatch_cost);
                best = diag + pair;
                if (up - gap > best)
                    best = up - gap;
                if (row[j-1] - gap > best)
                    best = row[j-1] - gap;
                row[j] = best;
                diag   = up;
            end
        end
        best = row[second_len];
        if (best > 32767)
            return SCORE_MAX;
        if (best < -32768)
            return SCORE_MIN;
        return best[SCORE_W-1:0];
    endfunction

    // Fold one accepted request into the predictor; a last request yields
    // the score and clears the data set.
    task automatic absorb_request(input item_t req, output bit scored,
                                  output result_t outcome);
        scored  = 1'b0;
        outcome = '0;
        if (req.symbol_present)
        begin
            if (!req.which_sequence)
            begin
                if (first_len < MAX_LEN)
                begin
                    first_seq[first_len] = req.symbol;
                    first_len++;
                end
                else
                    symbols_lost = 1'b1;
            end
            else
            begin
                if (second_len < MAX_LEN)
                begin
                    second_seq[second_len] = req.symbol;
                    second_len++;
                end
                else
                    symbols_lost = 1'b1;
            end
        end
        if (req.last)
        begin
            outcome.score    = alignment_score();
            outcome.overflow = symbols_lost;
            scored           = 1'b1;
            scored_sets++;
            if (symbols_lost)
                lost_sets++;
            first_len    = 0;
            second_len   = 0;
            symbols_lost = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic item_t make_item(input logic [SYM_W-1:0] sym, input logic seq,
                                        input logic present, input logic fin);
        item_t req;
        req.symbol         = sym;
        req.which_sequence = seq;
        req.symbol_present = present;
        req.last           = fin;
        return req;
    endfunction

    function automatic directed_row_t dir_row(input item_t req, input logic typed,
                                              input int score, input logic ovf);
        directed_row_t r;
        r.req      = req;
        r.typed    = typed;
        r.score    = score[SCORE_W-1:0];
        r.overflow = ovf;
        return r;
    endfunction

    // spread 0 draws from the full byte range; otherwise a narrow alphabet
    // starting at base, so that matches are common.
    function automatic logic [SYM_W-1:0] pick_symbol(input int base, input int spread);
        logic [SYM_W-1:0] s;
        if (spread == 0)
            s = SYM_W'($urandom_range(0, 255));
        else
            s = SYM_W'(base + $urandom_range(0, spread - 1));
        return s;
    endfunction

    // Drop start and hold it low while the sender idles.
    task automatic idle_cycles(input int n);
        if (start)
            start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Burst pacing: a random gap (when gaps are on), then a random run of back-to-back requests.
    task automatic pace();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                idle_cycles($urandom_range(1, 8));
        end
        burst_left--;
    endtask

    // Present one request and hold it until an edge sees start high and busy
    // low. start is raised only if it is low, so it never gets two updates
    // in one step.
    task automatic send_request(input item_t req);
        if (!start)
            start <= 1'b1;
        item <= req;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic issue_request(input item_t req);
        bit      scored;
        result_t outcome;
        pace();
        send_request(req);
        absorb_request(req, scored, outcome);
        if (scored)
            scores_due.push_back(outcome);
        if (req.symbol_present || req.last)
            request_count++;
    endtask

    // Park the sender until every owed score has arrived and busy is low,
    // then let the block settle.
    task automatic wait_idle();
        if (start)
            start <= 1'b0;
        do
            @(posedge clk);
        while (scores_due.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // One register write on the configuration channel; mirror it locally.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        if (!cfg_valid)
            cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_GAP:      gap_cost      = value;
            REG_MISMATCH: mismatch_cost = value;
            REG_MATCH:    match_bonus   = value;
            default:      ;
        endcase
    endtask

    task automatic program_registers(input logic [CFG_W-1:0] gap,
                                     input logic [CFG_W-1:0] mismatch,
                                     input logic [CFG_W-1:0] match,
                                     input bit poke_unused);
        write_register(REG_GAP, gap);
        if (poke_unused)
            write_register(REG_UNUSED, CFG_W'($urandom_range(0, 255)));
        write_register(REG_MISMATCH, mismatch);
        write_register(REG_MATCH, match);
        cfg_valid <= 1'b0;
    endtask

    // Feed one data set of the given lengths, interleaving the two sequences
    // at random. The closing request carries the final symbol half the time,
    // else it is end-only. Lengths past MAX_LEN exercise the drop path.
    task automatic run_data_set(input int len_a, input int len_b, input int spread);
        int  left_a;
        int  left_b;
        int  base;
        bit  carry_on_last;
        bit  seq;
        bit  fin;
        left_a        = len_a;
        left_b        = len_b;
        base          = $urandom_range(0, 252);
        carry_on_last = (len_a + len_b > 0) && ($urandom_range(0, 1) == 1);
        while (left_a + left_b > 0)
        begin
            // Sprinkle items that carry nothing; the block must ignore them.
            if ($urandom_range(0, 99) < 4)
                issue_request(make_item(SYM_W'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1)), 1'b0, 1'b0));
            if (left_a == 0)
                seq = 1'b1;
            else if (left_b == 0)
                seq = 1'b0;
            else
                seq = 1'($urandom_range(0, 1));
            fin = carry_on_last && (left_a + left_b == 1);
            issue_request(make_item(pick_symbol(base, spread), seq, 1'b1, fin));
            if (seq)
                left_b--;
            else
                left_a--;
        end
        if (!carry_on_last)
            issue_request(make_item(SYM_W'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), 1'b0, 1'b1));
    endtask

    // Mostly short sets so the quadratic scoring pass stays cheap; a few
    // medium ones, a few with one empty side, a few that overrun capacity.
    task automatic run_random_set();
        int pick;
        int len_a;
        int len_b;
        int spread;
        int swap;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       spread = 1;
            1:       spread = 2;
            2:       spread = 4;
            default: spread = 0;
        endcase
        if (pick < 6)
        begin
            len_a = 0;
            len_b = $urandom_range(0, 6);
        end
        else if (pick < 82)
        begin
            len_a = $urandom_range(1, 10);
            len_b = $urandom_range(1, 10);
        end
        else if (pick < 96)
        begin
            len_a = $urandom_range(11, 40);
            len_b = $urandom_range(1, 40);
        end
        else
        begin
            len_a = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
            len_b = $urandom_range(0, 5);
        end
        swap = $urandom_range(0, 1);
        if (swap == 1)
            run_data_set(len_b, len_a, spread);
        else
            run_data_set(len_a, len_b, spread);
    endtask

    function automatic logic [CFG_W-1:0] pick_register_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return CFG_W'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        bit      scored;
        result_t outcome;
        result_t typed_result;
        int      k;
        int      phase;
        int      phase_start;

        // Every input known from time zero; reset asserted first, then released.
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_GAP;
        cfg_data  <= '0;

        // Directed table, reset registers: gap 1, mismatch 2, match 4.
        // Rows with a typed score are simple enough to read off directly.
        directed_rows[0]  = dir_row(make_item(8'h00, 1'b0, 1'b0, 1'b1), 1'b1, 0, 1'b0);
        directed_rows[1]  = dir_row(make_item(8'hAA, 1'b1, 1'b0, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[2]  = dir_row(make_item(8'hFF, 1'b0, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[3]  = dir_row(make_item(8'hFF, 1'b1, 1'b1, 1'b1), 1'b1, 4, 1'b0);
        directed_rows[4]  = dir_row(make_item(8'h00, 1'b0, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[5]  = dir_row(make_item(8'h01, 1'b1, 1'b1, 1'b1), 1'b1, -2, 1'b0);
        directed_rows[6]  = dir_row(make_item(8'h10, 1'b0, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[7]  = dir_row(make_item(8'h20, 1'b0, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[8]  = dir_row(make_item(8'h30, 1'b0, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[9]  = dir_row(make_item(8'h00, 1'b0, 1'b0, 1'b1), 1'b1, -3, 1'b0);
        directed_rows[10] = dir_row(make_item(8'h55, 1'b1, 1'b1, 1'b1), 1'b1, -1, 1'b0);
        directed_rows[11] = dir_row(make_item(8'h33, 1'b0, 1'b1, 1'b1), 1'b1, -1, 1'b0);
        directed_rows[12] = dir_row(make_item(8'h41, 1'b0, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[13] = dir_row(make_item(8'h42, 1'b0, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[14] = dir_row(make_item(8'h41, 1'b1, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[15] = dir_row(make_item(8'h42, 1'b1, 1'b1, 1'b1), 1'b1, 8, 1'b0);
        directed_rows[16] = dir_row(make_item(8'h80, 1'b0, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[17] = dir_row(make_item(8'h7F, 1'b1, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[18] = dir_row(make_item(8'h80, 1'b1, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[19] = dir_row(make_item(8'h01, 1'b0, 1'b1, 1'b0), 1'b0, 0, 1'b0);
        directed_rows[20] = dir_row(make_item(8'hFE, 1'b1, 1'b1, 1'b1), 1'b0, 0, 1'b0);
        directed_rows[21] = dir_row(make_item(8'hFF, 1'b1, 1'b0, 1'b1), 1'b1, 0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table. The predictor always advances so its state stays
        // aligned; typed rows are checked against their typed score.
        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            pace();
            send_request(directed_rows[k].req);
            absorb_request(directed_rows[k].req, scored, outcome);
            if (scored)
            begin
                typed_result.score    = directed_rows[k].score;
                typed_result.overflow = directed_rows[k].overflow;
                scores_due.push_back(directed_rows[k].typed ? typed_result : outcome);
            end
            request_count++;
        end

        // Random phases: settle, reprogram the registers (extremes first),
        // open with one heavy set, then random sets until the phase quota.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:       program_registers(8'd255, 8'd255, 8'd255, 1'b1);
                1:       program_registers(8'd0, 8'd0, 8'd0, 1'b0);
                2:       program_registers(8'd255, 8'd0, 8'd0, 1'b1);
                3:       program_registers(8'd0, 8'd255, 8'd255, 1'b0);
                default: program_registers(pick_register_value(), pick_register_value(),
                                           pick_register_value(), phase[0]);
            endcase
            // Run some phases without sender gaps at all.
            gaps_on     = (phase % 3) != 2;
            phase_start = request_count;

            // Even phases: full 64 x 64 set on a one-symbol alphabet.
            // Odd phases: first sequence overrun, second empty.
            if (phase[0] == 1'b0)
                run_data_set(MAX_LEN, MAX_LEN, 1);
            else
                run_data_set(MAX_LEN + 2, 0, 0);

            while (request_count - phase_start < PHASE_REQUESTS)
            begin
                run_random_set();
                // Now and then hold the sender until the block has drained.
                if ($urandom_range(0, 99) < 8)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (scores_due.size() != 0)
            $error("%0d scores never arrived", scores_due.size());

        $display("Covered %0d requests in %0d scored data sets, %0d of them with dropped symbols,",
                 request_count, scored_sets, lost_sets);
        $display("across the reset registers and %0d reprogrammed register settings.",
                 NUM_PHASES);
        if (errors == 0 && scores_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
